[src/ihlt_pkg.sv]
package ihlt_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam int FUNC_W = 2;
  localparam int ID_W = 10;
  localparam int TAG_W = 32;
  localparam int WORD_W = 32;
  localparam int ST_W = 3;

  localparam logic [FUNC_W-1:0] FN_REGISTER = 2'd0;
  localparam logic [FUNC_W-1:0] FN_UNREGISTER = 2'd1;
  localparam logic [FUNC_W-1:0] FN_DISPATCH = 2'd2;

  localparam logic [ST_W-1:0] ST_OK = 3'd0;
  localparam logic [ST_W-1:0] ST_NULL = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_SPURIOUS = 3'd4;

  localparam logic [ID_W-1:0] SPURIOUS_ID = 10'h3FF;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [TAG_W-1:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic we;
    logic [ADDR_W-1:0] waddr;
    entry_t wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [TAG_W-1:0] found_tag;
    logic eoi_valid;
    logic [WORD_W-1:0] eoi_word;
  } res_t;

endpackage

[src/ihlt_ram.sv]
module ihlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/ihlt_ctrl.sv]
module ihlt_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               func,
  input  logic [9:0]               intid,
  input  logic [31:0]              handler_tag,
  input  logic [31:0]              ack_word,
  output ihlt_pkg::ram_req_t       ram_req,
  input  ihlt_pkg::entry_t         ram_rdata,
  output logic                     res_valid,
  input  logic                     res_ready,
  output ihlt_pkg::res_t           res
);

  import ihlt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_MOVE_RD = 3'd2;
  localparam logic [2:0] S_MOVE_WR = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic pv, pv_next;
  logic [ADDR_W-1:0] pidx, pidx_next;
  logic [ADDR_W-1:0] slot, slot_next;
  logic [FUNC_W-1:0] op, op_next;
  logic [ID_W-1:0] key, key_next;
  logic [TAG_W-1:0] tag, tag_next;
  logic [WORD_W-1:0] ack, ack_next;
  res_t res_next;

  logic accept;
  logic rd_en;
  logic hit;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign res_valid = (state == S_FINISH);

  // The one comparator: the entry read last cycle against the search key.
  assign rd_en = (state == S_SEARCH) && (idx < count);
  assign hit = pv && (ram_rdata.id == key);

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next = idx;
    pv_next = 1'b0;
    pidx_next = pidx;
    slot_next = slot;
    op_next = op;
    key_next = key;
    tag_next = tag;
    ack_next = ack;
    res_next = res;
    ram_req.we = 1'b0;
    ram_req.waddr = pidx;
    ram_req.wdata = '{id: key, tag: tag};
    ram_req.raddr = idx[ADDR_W-1:0];

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op_next = func;
          tag_next = handler_tag;
          ack_next = ack_word;
          key_next = (func == FN_DISPATCH) ? ack_word[ID_W-1:0] : intid;
          idx_next = '0;
          res_next = '0;
          state_next = S_SEARCH;
          unique case (func)
            FN_REGISTER: begin
              if (handler_tag == '0) begin
                res_next.status = ST_NULL;
                state_next = S_FINISH;
              end
            end
            FN_UNREGISTER: begin
            end
            FN_DISPATCH: begin
              if (ack_word[ID_W-1:0] == SPURIOUS_ID) begin
                res_next.status = ST_SPURIOUS;
                state_next = S_FINISH;
              end
            end
            default: begin
              state_next = S_FINISH;
            end
          endcase
        end
      end

      S_SEARCH: begin
        // Reads run one entry ahead of the compare.
        pv_next = rd_en;
        pidx_next = idx[ADDR_W-1:0];
        idx_next = idx + CNT_W'(rd_en);
        if (hit) begin
          pv_next = 1'b0;
          unique case (op)
            FN_REGISTER: begin
              ram_req.we = 1'b1;
              ram_req.waddr = pidx;
              state_next = S_FINISH;
            end
            FN_UNREGISTER: begin
              count_next = count - CNT_W'(1);
              slot_next = pidx;
              state_next = S_MOVE_RD;
            end
            default: begin
              res_next.found_tag = ram_rdata.tag;
              res_next.eoi_valid = 1'b1;
              res_next.eoi_word = ack;
              state_next = S_FINISH;
            end
          endcase
        end else if (!pv && !rd_en) begin
          state_next = S_FINISH;
          unique case (op)
            FN_REGISTER: begin
              if (count == CNT_W'(MAX_ENTRIES)) begin
                res_next.status = ST_FULL;
              end else begin
                ram_req.we = 1'b1;
                ram_req.waddr = count[ADDR_W-1:0];
                count_next = count + CNT_W'(1);
              end
            end
            FN_UNREGISTER: begin
              res_next.status = ST_NOT_FOUND;
            end
            default: begin
              res_next.status = ST_NOT_FOUND;
              res_next.eoi_valid = 1'b1;
              res_next.eoi_word = ack;
            end
          endcase
        end
      end

      S_MOVE_RD: begin
        // Count was already decremented, so it now points at the last entry.
        ram_req.raddr = count[ADDR_W-1:0];
        state_next = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        ram_req.we = 1'b1;
        ram_req.waddr = slot;
        ram_req.wdata = ram_rdata;
        state_next = S_FINISH;
      end

      S_FINISH: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pv <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pv <= pv_next;
    end
    idx <= idx_next;
    pidx <= pidx_next;
    slot <= slot_next;
    op <= op_next;
    key <= key_next;
    tag <= tag_next;
    ack <= ack_next;
    res <= res_next;
  end

endmodule

[src/interrupt_handler_lookup_table_unit.sv]
// Channel  Handshake            Word
// in       in_valid / in_stall  func, intid, handler_tag, ack_word
// out      out_valid / out_stall status, found_tag, eoi_valid, eoi_word
//
// An item holds the block from acceptance until its result word enters the output register,
// longer while a full output register is stalled. The table is scanned one entry per cycle
// through the single read port of the entry RAM; an unregister that finds its entry then
// passes S_MOVE_RD and S_MOVE_WR to move the last entry into the freed slot. Reset empties
// the table at once (count only).
// A stalled output holds its word; the next item may be taken while it waits.
module interrupt_handler_lookup_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [9:0]  intid,
  input  logic [31:0] handler_tag,
  input  logic [31:0] ack_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] found_tag,
  output logic        eoi_valid,
  output logic [31:0] eoi_word
);

  import ihlt_pkg::*;

  ram_req_t ram_req;
  logic [ENTRY_W-1:0] rdata_raw;
  entry_t ram_rdata;
  logic res_valid;
  logic res_ready;
  res_t res;
  logic load;

  assign ram_rdata = entry_t'(rdata_raw);

  ihlt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk(clk),
    .we(ram_req.we),
    .waddr(ram_req.waddr),
    .wdata(ENTRY_W'(ram_req.wdata)),
    .raddr(ram_req.raddr),
    .rdata(rdata_raw)
  );

  ihlt_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .intid(intid),
    .handler_tag(handler_tag),
    .ack_word(ack_word),
    .ram_req(ram_req),
    .ram_rdata(ram_rdata),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  assign res_ready = !out_valid || !out_stall;
  assign load = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load || (out_valid && out_stall);
    end
    if (load) begin
      status <= res.status;
      found_tag <= res.found_tag;
      eoi_valid <= res.eoi_valid;
      eoi_word <= res.eoi_word;
    end
  end

endmodule

[src/ihlt_checker.sv]
module ihlt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  func,
  input logic [9:0]  intid,
  input logic [31:0] handler_tag,
  input logic [31:0] ack_word,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [31:0] found_tag,
  input logic        eoi_valid,
  input logic [31:0] eoi_word
);

  import ihlt_pkg::*;

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item was in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(found_tag)
      && $stable(eoi_valid) && $stable(eoi_word)))
    else $error("stalled result word changed");

  a_eoi_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && eoi_valid) |-> (status == ST_OK || status == ST_NOT_FOUND))
    else $error("end-of-interrupt request with a wrong status");

  a_tag_only_on_dispatch: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found_tag != '0) |-> (status == ST_OK && eoi_valid))
    else $error("handler tag returned outside a successful dispatch");

  a_eoi_word_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !eoi_valid) |-> (eoi_word == '0))
    else $error("end-of-interrupt word set without a request");

endmodule

bind interrupt_handler_lookup_table_unit ihlt_checker u_ihlt_checker (.*);
